// ----- rtl/core/nlp_pkg.sv -----
package nlp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_SIGN = 3'd1,
    PH_ZERO = 3'd2,
    PH_HEX  = 3'd3,
    PH_DEC  = 3'd4
  } phase_e;

  localparam logic [7:0]  CHAR_MINUS      = 8'h2d;
  localparam logic [7:0]  CHAR_UNDERSCORE = 8'h5f;
  localparam logic [7:0]  CHAR_LOWER_X    = 8'h78;
  localparam logic [7:0]  CHAR_ZERO       = 8'h30;
  localparam logic [7:0]  CHAR_NINE       = 8'h39;
  localparam logic [7:0]  CHAR_LOWER_A    = 8'h61;
  localparam logic [7:0]  CHAR_LOWER_F    = 8'h66;
  localparam logic [7:0]  CHAR_UPPER_A    = 8'h41;
  localparam logic [7:0]  CHAR_UPPER_F    = 8'h46;
  localparam logic [11:0] CNT_MAX         = 12'hfff;
  localparam logic [63:0] DEC_LIMIT       = 64'd1844674407370955161;

  typedef struct packed {
    phase_e      phase;
    logic [63:0] acc;
    logic        negative;
    logic [11:0] consumed;
  } state_t;

  typedef struct packed {
    logic [63:0] value;
    logic [11:0] used_count;
    logic [7:0]  stop_char;
    logic        overflow_stop;
  } result_t;

  // {is_digit, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      r = {1'b1, 4'(c - CHAR_ZERO)};
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      r = {1'b1, 4'(c - CHAR_LOWER_A + 8'd10)};
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      r = {1'b1, 4'(c - CHAR_UPPER_A + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic [11:0] bump(input logic [11:0] cnt);
    return (cnt == CNT_MAX) ? cnt : cnt + 12'd1;
  endfunction

endpackage

// ----- rtl/core/nlp_in_if.sv -----
interface nlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       begin_req;

  modport source(output valid, output char_in, output begin_req, input ready);
  modport sink(input valid, input char_in, input begin_req, output ready);
endinterface

// ----- rtl/core/nlp_out_if.sv -----
interface nlp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [11:0] used_count;
  logic [7:0]  stop_char;
  logic        overflow_stop;

  modport source(output valid, output value, output used_count, output stop_char,
                 output overflow_stop, input ready);
  modport sink(input valid, input value, input used_count, input stop_char,
               input overflow_stop, output ready);
endinterface

// ----- rtl/core/nlp_step.sv -----
module nlp_step (
  input  nlp_pkg::state_t  cur_i,
  input  logic [7:0]       char_i,
  input  logic             begin_i,
  output nlp_pkg::state_t  nxt_o,
  output logic             emit_o,
  output nlp_pkg::result_t res_o
);

  logic [63:0] acc_v;
  logic [11:0] cnt_v;
  logic        neg_v;
  logic        do_start;
  logic        do_dec;
  logic        do_hex;
  logic        finish;
  logic        ovf;
  logic [4:0]  hex_d;
  logic        is_dec;
  logic        is_us;
  logic [63:0] acc_x10;

  assign acc_v   = begin_i ? 64'd0 : cur_i.acc;
  assign cnt_v   = begin_i ? 12'd0 : cur_i.consumed;
  assign neg_v   = begin_i ? 1'b0 : cur_i.negative;
  assign hex_d   = nlp_pkg::hex_decode(char_i);
  assign is_dec  = (char_i >= nlp_pkg::CHAR_ZERO) && (char_i <= nlp_pkg::CHAR_NINE);
  assign is_us   = (char_i == nlp_pkg::CHAR_UNDERSCORE);
  assign acc_x10 = {acc_v[60:0], 3'b000} + {acc_v[62:0], 1'b0} + {60'd0, hex_d[3:0]};

  always_comb begin
    nxt_o          = cur_i;
    nxt_o.acc      = acc_v;
    nxt_o.consumed = cnt_v;
    nxt_o.negative = neg_v;
    do_start = 1'b0;
    do_dec   = 1'b0;
    do_hex   = 1'b0;
    finish   = 1'b0;
    ovf      = 1'b0;

    if (begin_i) begin
      if (char_i == nlp_pkg::CHAR_MINUS) begin
        nxt_o.negative = 1'b1;
        nxt_o.consumed = nlp_pkg::bump(cnt_v);
        nxt_o.phase    = nlp_pkg::PH_SIGN;
      end else begin
        do_start = 1'b1;
      end
    end else begin
      unique case (cur_i.phase)
        nlp_pkg::PH_SIGN: do_start = 1'b1;
        nlp_pkg::PH_ZERO: begin
          if (char_i == nlp_pkg::CHAR_LOWER_X) begin
            nxt_o.consumed = nlp_pkg::bump(cnt_v);
            nxt_o.phase    = nlp_pkg::PH_HEX;
          end else begin
            do_dec = 1'b1;
          end
        end
        nlp_pkg::PH_HEX: do_hex = 1'b1;
        nlp_pkg::PH_DEC: do_dec = 1'b1;
        default: nxt_o.phase = nlp_pkg::PH_IDLE;
      endcase
    end

    if (do_start) begin
      if (char_i == nlp_pkg::CHAR_ZERO) begin
        nxt_o.consumed = nlp_pkg::bump(cnt_v);
        nxt_o.phase    = nlp_pkg::PH_ZERO;
      end else begin
        do_dec = 1'b1;
      end
    end

    if (do_dec) begin
      nxt_o.phase = nlp_pkg::PH_DEC;
      if (is_dec) begin
        if (acc_v > nlp_pkg::DEC_LIMIT) begin
          finish = 1'b1;
          ovf    = 1'b1;
        end else begin
          nxt_o.acc      = acc_x10;
          nxt_o.consumed = nlp_pkg::bump(cnt_v);
        end
      end else if (is_us) begin
        nxt_o.consumed = nlp_pkg::bump(cnt_v);
      end else begin
        finish = 1'b1;
      end
    end

    if (do_hex) begin
      if (hex_d[4]) begin
        if (acc_v[63:60] != 4'd0) begin
          finish = 1'b1;
          ovf    = 1'b1;
        end else begin
          nxt_o.acc      = {acc_v[59:0], hex_d[3:0]};
          nxt_o.consumed = nlp_pkg::bump(cnt_v);
        end
      end else if (is_us) begin
        nxt_o.consumed = nlp_pkg::bump(cnt_v);
      end else begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      nxt_o.phase = nlp_pkg::PH_IDLE;
    end
  end

  assign emit_o              = finish;
  assign res_o.value         = neg_v ? (64'd0 - acc_v) : acc_v;
  assign res_o.used_count    = cnt_v;
  assign res_o.stop_char     = char_i;
  assign res_o.overflow_stop = ovf;

endmodule

// ----- rtl/core/numeric_literal_parser.sv -----
// Streaming integer literal parser, 64-bit result.
// in_i (sink): one text byte per item, char_in plus begin_req marking the
//   first byte of a new token. A begin drops any unfinished token.
// out_o (source): one item per finished token: value (negated mod 2^64 after
//   a leading minus), used_count (saturating at 4095), stop_char and
//   overflow_stop. Bytes that do not end a token give no item.
// Path: an accepted byte is held in the input register and decoded from it;
//   its result, if any, is then written to the output register.
// Throughput: one byte per cycle unless a token-ending byte must wait (see
//   Stall). The per-byte step (times ten plus digit, or shift by four) sits
//   between the input register and the state and result registers.
// Stall: a result waits in the output register; bytes that end no token keep
//   flowing past it. Only a byte that ends a token while the output register
//   is full and out_o.ready is low waits in the input register; ready drops.
// Reset: no token active, both registers empty.
module numeric_literal_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  nlp_in_if.sink       in_i,
  nlp_out_if.source    out_o
);

  logic              in_valid_q;
  logic [7:0]        char_q;
  logic              begin_q;
  nlp_pkg::state_t   state_q;
  nlp_pkg::state_t   state_d;
  logic              out_valid_q;
  nlp_pkg::result_t  res_q;
  nlp_pkg::result_t  res_d;
  logic              emit;
  logic              advance;
  logic              in_fire;

  nlp_step u_step (
    .cur_i   (state_q),
    .char_i  (char_q),
    .begin_i (begin_q),
    .nxt_o   (state_d),
    .emit_o  (emit),
    .res_o   (res_d)
  );

  assign advance  = in_valid_q && (!emit || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_fire  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q  <= in_i.char_in;
      begin_q <= in_i.begin_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: nlp_pkg::PH_IDLE, acc: 64'd0, negative: 1'b0, consumed: 12'd0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.value         = res_q.value;
  assign out_o.used_count    = res_q.used_count;
  assign out_o.stop_char     = res_q.stop_char;
  assign out_o.overflow_stop = res_q.overflow_stop;

`ifndef SYNTHESIS
  a_phase_idle_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |=> state_q.phase == nlp_pkg::PH_IDLE)
    else $error("token still active after its result");

  a_no_emit_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready && emit |-> !advance)
    else $error("result overwrote a pending one");

  a_ovf_on_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.overflow_stop |-> nlp_pkg::hex_decode(res_q.stop_char) != 5'd0)
    else $error("overflow stop on a non-digit byte");
`endif

endmodule
